[design/utf8d_pkg.sv]
package utf8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned OUT_TDATA_W = 24;

  // bytes_expected code that marks no sequence in progress
  localparam logic [CNT_W-1:0] IDLE_MARK = 3'd7;

  localparam logic [BYTE_W-1:0] ASCII_MAX   = 8'h7F;
  localparam logic [BYTE_W-1:0] CONT_MAX    = 8'hBF;
  localparam logic [BYTE_W-1:0] LEAD2_MIN   = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MIN   = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MIN   = 8'hF0;
  localparam logic [BYTE_W-1:0] INVALID_MIN = 8'hF8;

  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;

  localparam logic [CP_W-1:0] REMAP_BASE = 21'h000410;

  typedef struct packed {
    logic [CNT_W-1:0] bytes_expected;
    logic [CNT_W-1:0] bytes_seen;
    logic [CP_W-1:0]  partial_code;
  } dec_state_t;

  localparam dec_state_t STATE_IDLE = '{
    bytes_expected: IDLE_MARK,
    bytes_seen:     '0,
    partial_code:   '0
  };

endpackage

[design/utf8_byte_decoder_core.sv]
// Byte-serial UTF-8 decoder. Every byte request on the input stream yields exactly one
// code point request on the output stream, 0 when no character completes on that byte.
// A zero byte clears the decoder; lead bytes C0/E0/F0 open sequences of one to three
// continuation bytes, and a byte above BF in mid-sequence aborts and is lost. Setting
// cfg_wdata to 1 (with cfg_we) selects a stateless remap of C0..FF onto 0x410 upward.
// Throughput is one byte per clock while out_tready does not stall the output: the whole
// update is one pass of compare and shift logic between an input register and an output
// register, and the decoder state is written in the same cycle a byte moves to the output.
// The output register lets a new byte enter while a result waits for out_tready. Change the
// mode only while the stream is empty.
module utf8_byte_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  // mode register
  logic remap_mode_r;

  // input register
  logic                             in_valid_r;
  logic [utf8d_pkg::BYTE_W-1:0]     in_byte_r;

  // decoder state
  utf8d_pkg::dec_state_t            state_r;
  utf8d_pkg::dec_state_t            state_nxt;

  // output register
  logic                             out_valid_r;
  logic [utf8d_pkg::CP_W-1:0]       out_code_r;
  logic [utf8d_pkg::CP_W-1:0]       code_nxt;

  // the held byte moves on when the output slot is free or being drained
  logic advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remap_mode_r <= 1'b0;
    end else if (cfg_we) begin
      remap_mode_r <= cfg_wdata;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  utf8d_step u_step (
    .remap_mode (remap_mode_r),
    .byte_in    (in_byte_r),
    .state_cur  (state_r),
    .state_nxt  (state_nxt),
    .code_point (code_nxt)
  );

  // state only moves when a byte is committed to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= utf8d_pkg::STATE_IDLE;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_code_r <= code_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(utf8d_pkg::OUT_TDATA_W-utf8d_pkg::CP_W){1'b0}}, out_code_r};

endmodule

[design/utf8d_step.sv]
module utf8d_step (
  input  logic                                remap_mode,
  input  logic [utf8d_pkg::BYTE_W-1:0]        byte_in,
  input  utf8d_pkg::dec_state_t               state_cur,
  output utf8d_pkg::dec_state_t               state_nxt,
  output logic [utf8d_pkg::CP_W-1:0]          code_point
);

  logic [utf8d_pkg::CP_W-1:0]  shifted_code;
  logic [utf8d_pkg::CNT_W-1:0] seen_inc;

  assign seen_inc = state_cur.bytes_seen + 3'd1;
  assign shifted_code = {state_cur.partial_code[utf8d_pkg::CP_W-7:0], byte_in[5:0]};

  always_comb begin
    state_nxt  = state_cur;
    code_point = '0;
    if (remap_mode) begin
      // stateless single-byte remap, C0..FF land on 0x410 upward
      if (byte_in >= utf8d_pkg::LEAD2_MIN) begin
        code_point = utf8d_pkg::REMAP_BASE
                     + {{(utf8d_pkg::CP_W-6){1'b0}}, byte_in[5:0]};
      end else begin
        code_point = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, byte_in};
      end
    end else if (byte_in == '0) begin
      state_nxt = utf8d_pkg::STATE_IDLE;
    end else if (state_cur.bytes_expected == utf8d_pkg::IDLE_MARK) begin
      state_nxt.partial_code = '0;
      if (byte_in >= utf8d_pkg::INVALID_MIN) begin
        code_point = '0;
      end else if (byte_in <= utf8d_pkg::ASCII_MAX) begin
        code_point = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, byte_in};
      end else begin
        state_nxt.bytes_seen = '0;
        if (byte_in >= utf8d_pkg::LEAD4_MIN) begin
          state_nxt.partial_code = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}},
                                    byte_in & utf8d_pkg::LEAD4_MASK};
          state_nxt.bytes_expected = 3'd3;
        end else if (byte_in >= utf8d_pkg::LEAD3_MIN) begin
          state_nxt.partial_code = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}},
                                    byte_in & utf8d_pkg::LEAD3_MASK};
          state_nxt.bytes_expected = 3'd2;
        end else if (byte_in >= utf8d_pkg::LEAD2_MIN) begin
          state_nxt.partial_code = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}},
                                    byte_in & utf8d_pkg::LEAD2_MASK};
          state_nxt.bytes_expected = 3'd1;
        end
      end
    end else begin
      if (state_cur.bytes_seen <= state_cur.bytes_expected) begin
        state_nxt.partial_code = shifted_code;
        state_nxt.bytes_seen   = seen_inc;
      end
      if (byte_in > utf8d_pkg::CONT_MAX) begin
        // abort, the byte itself is dropped
        state_nxt.bytes_expected = utf8d_pkg::IDLE_MARK;
      end else if (state_nxt.bytes_seen == state_cur.bytes_expected) begin
        state_nxt.bytes_expected = utf8d_pkg::IDLE_MARK;
        state_nxt.bytes_seen     = utf8d_pkg::IDLE_MARK;
        code_point               = state_nxt.partial_code;
      end
    end
  end

endmodule

[design/utf8d_checker.sv]
module utf8d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // padding bits above the code point stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:21] == 3'd0)
    else $error("nonzero padding in out_tdata");

  // with nothing waiting on the output the input side is never stalled
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind utf8_byte_decoder_core utf8d_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/tb_utf8_byte_decoder_core.sv]
`timescale 1ns / 100ps

module tb_utf8_byte_decoder_core;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned PHASE_BYTES = 150;
  localparam int unsigned NUM_PHASES  = 6;
  localparam int unsigned NUM_ROWS    = 27;

  // directed table columns
  localparam logic DEC = 1'b0;  // utf-8 decode mode
  localparam logic REM = 1'b1;  // single-byte remap mode
  localparam logic CHK = 1'b1;  // expected code point typed in the row
  localparam logic PRD = 1'b0;  // expected code point taken from the predictor

  typedef logic [utf8d_pkg::CP_W-1:0] cp_t;

  typedef struct packed {
    logic       remap;
    logic       known;
    logic [7:0] data;
    cp_t        cp;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] byte_in
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [20:0] code_point, [23:21] zero
  logic        cfg_we;
  logic        cfg_wdata;

  // predictor state, a private copy of the decoder and the mode register
  utf8d_pkg::dec_state_t dec_st;
  logic                  remap_on;

  // code points still owed by the block, oldest first
  cp_t cp_pending [$];

  int unsigned cycle_count = 0;
  int unsigned errors      = 0;
  int unsigned bytes_sent;
  int unsigned remap_bytes;
  int unsigned cp_seen     = 0;
  int unsigned cp_nonzero  = 0;
  bit          smooth;     // no idling on either side while set
  bit          hold_req;   // asks the receiver for one long hold-off

  // directed part: extremes, ascii, stray and invalid bytes, every sequence
  // length, abort, ascii taken as continuation, zero clear, remap extremes
  stim_row_t directed_rows [0:NUM_ROWS-1] = '{
    {DEC, CHK, 8'h41, 21'h000041},  // plain ascii
    {DEC, CHK, 8'h7F, 21'h00007F},  // top of ascii
    {DEC, CHK, 8'h00, 21'h000000},  // zero byte while idle
    {DEC, CHK, 8'h80, 21'h000000},  // stray continuation
    {DEC, CHK, 8'hFF, 21'h000000},  // invalid lead
    {DEC, CHK, 8'hC3, 21'h000000},  // two-byte sequence
    {DEC, CHK, 8'hA9, 21'h0000E9},
    {DEC, CHK, 8'hF0, 21'h000000},  // four-byte sequence
    {DEC, CHK, 8'h9F, 21'h000000},
    {DEC, CHK, 8'h98, 21'h000000},
    {DEC, PRD, 8'h80, 21'h000000},
    {DEC, CHK, 8'hF7, 21'h000000},  // largest code point
    {DEC, CHK, 8'hBF, 21'h000000},
    {DEC, CHK, 8'hBF, 21'h000000},
    {DEC, CHK, 8'hBF, 21'h1FFFFF},
    {DEC, CHK, 8'hC0, 21'h000000},  // abort, the aborting byte is lost
    {DEC, CHK, 8'hC5, 21'h000000},
    {DEC, CHK, 8'h41, 21'h000041},
    {DEC, CHK, 8'hE0, 21'h000000},  // ascii inside a sequence
    {DEC, CHK, 8'h41, 21'h000000},
    {DEC, PRD, 8'h7F, 21'h000000},
    {DEC, CHK, 8'hD0, 21'h000000},  // zero byte clears a sequence
    {DEC, CHK, 8'h00, 21'h000000},
    {DEC, CHK, 8'h80, 21'h000000},
    {REM, CHK, 8'hC0, 21'h000410},  // remap extremes
    {REM, CHK, 8'hFF, 21'h00044F},
    {REM, CHK, 8'h00, 21'h000000}
  };

  utf8_byte_decoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // expected code point for one byte; advances the private decoder state
  function automatic cp_t predict_code_point(input logic [7:0] b);
    if (remap_on) begin
      // stateless, C0..FF land on the cyrillic block
      if (b >= utf8d_pkg::LEAD2_MIN)
        return utf8d_pkg::REMAP_BASE + cp_t'(b - utf8d_pkg::LEAD2_MIN);
      return cp_t'(b);
    end
    if (b == 8'h00) begin
      dec_st = utf8d_pkg::STATE_IDLE;
      return '0;
    end
    if (dec_st.bytes_expected == utf8d_pkg::IDLE_MARK) begin
      dec_st.partial_code = '0;
      if (b >= utf8d_pkg::INVALID_MIN)
        return '0;
      if (b <= utf8d_pkg::ASCII_MAX)
        return cp_t'(b);
      if (b >= utf8d_pkg::LEAD4_MIN) begin
        dec_st.partial_code   = cp_t'(b & utf8d_pkg::LEAD4_MASK);
        dec_st.bytes_expected = 3'd3;
      end else if (b >= utf8d_pkg::LEAD3_MIN) begin
        dec_st.partial_code   = cp_t'(b & utf8d_pkg::LEAD3_MASK);
        dec_st.bytes_expected = 3'd2;
      end else if (b >= utf8d_pkg::LEAD2_MIN) begin
        dec_st.partial_code   = cp_t'(b & utf8d_pkg::LEAD2_MASK);
        dec_st.bytes_expected = 3'd1;
      end
      // a stray continuation leaves the decoder idle
      dec_st.bytes_seen = '0;
      return '0;
    end
    // mid-sequence: any byte shifts its low six bits in first
    if (dec_st.bytes_seen <= dec_st.bytes_expected) begin
      dec_st.partial_code = {dec_st.partial_code[utf8d_pkg::CP_W-7:0], b[5:0]};
      dec_st.bytes_seen   = dec_st.bytes_seen + 3'd1;
    end
    // a lead-range byte aborts the sequence and is not reused
    if (b > utf8d_pkg::CONT_MAX) begin
      dec_st.bytes_expected = utf8d_pkg::IDLE_MARK;
      return '0;
    end
    if (dec_st.bytes_seen == dec_st.bytes_expected) begin
      dec_st.bytes_expected = utf8d_pkg::IDLE_MARK;
      dec_st.bytes_seen     = utf8d_pkg::IDLE_MARK;
      return dec_st.partial_code;
    end
    return '0;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (smooth || r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 98)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one byte request and wait for it to be taken
  task automatic push_byte(input logic [7:0] b, input logic known,
                           input cp_t typed_cp);
    int unsigned gap;
    cp_t pred;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    pred = predict_code_point(b);
    cp_pending.push_back(known ? typed_cp : pred);
    bytes_sent++;
    if (remap_on)
      remap_bytes++;
  endtask

  // drain the block, then write the mode register while nothing is in flight
  task automatic set_mode(input logic mode);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (cp_pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we    <= 1'b0;
    remap_on = mode;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned gap;
    bit          hold_done;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_tready <= 1'b1;
      end
    end
  end

  // compare every accepted code point request with the oldest expectation
  always @(posedge clk) begin
    cp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      cp_seen++;
      if (out_tdata[utf8d_pkg::CP_W-1:0] != '0)
        cp_nonzero++;
      if (cp_pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected code point, expected none, got %06h",
                 $time, out_tdata[utf8d_pkg::CP_W-1:0]);
      end else begin
        want = cp_pending.pop_front();
        if (out_tdata[utf8d_pkg::CP_W-1:0] !== want) begin
          errors++;
          $display("%0t: code_point mismatch, expected %06h, got %06h",
                   $time, want, out_tdata[utf8d_pkg::CP_W-1:0]);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned ph_bytes;
    int unsigned kind;
    int unsigned len;
    int unsigned k;
    logic        mode;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = 1'b0;
    rst_n       = 1'b0;
    smooth      = 1'b0;
    hold_req    = 1'b0;
    bytes_sent  = 0;
    remap_bytes = 0;
    remap_on    = 1'b0;
    dec_st      = utf8d_pkg::STATE_IDLE;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows start on the reset value of the mode register
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (directed_rows[i].remap != remap_on)
        set_mode(directed_rows[i].remap);
      push_byte(directed_rows[i].data, directed_rows[i].known, directed_rows[i].cp);
    end

    // random phases; mode is rewritten each phase, so a sequence left open
    // across a remap phase resumes when decoding comes back
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      mode = (ph == 1 || ph == 4);
      set_mode(mode);
      smooth = (ph == 3);
      if (ph == 2)
        hold_req = 1'b1;
      ph_bytes = 0;
      while (ph_bytes < PHASE_BYTES) begin
        kind = $urandom_range(0, 99);
        if (mode) begin
          // remap: whole byte range, weighted toward the remapped range C0..FF
          if (kind < 50)
            push_byte(8'($urandom_range(8'hC0, 8'hFF)), PRD, '0);
          else
            push_byte(8'($urandom_range(0, 255)), PRD, '0);
          ph_bytes++;
        end else if (kind < 65) begin
          // well-formed: ascii or a lead with its full run of continuations
          len = $urandom_range(0, 3);
          case (len)
            0: push_byte(8'($urandom_range(1, 8'h7F)), PRD, '0);
            1: push_byte(8'($urandom_range(8'hC0, 8'hDF)), PRD, '0);
            2: push_byte(8'($urandom_range(8'hE0, 8'hEF)), PRD, '0);
            default: push_byte(8'($urandom_range(8'hF0, 8'hF7)), PRD, '0);
          endcase
          for (int j = 0; j < len; j++)
            push_byte(8'($urandom_range(8'h80, 8'hBF)), PRD, '0);
          ph_bytes += len + 1;
        end else if (kind < 82) begin
          // broken: a run cut short by an abort byte or a zero, or fed an ascii byte taken as continuation
          len = $urandom_range(1, 3);
          case (len)
            1: push_byte(8'($urandom_range(8'hC0, 8'hDF)), PRD, '0);
            2: push_byte(8'($urandom_range(8'hE0, 8'hEF)), PRD, '0);
            default: push_byte(8'($urandom_range(8'hF0, 8'hF7)), PRD, '0);
          endcase
          k = $urandom_range(0, len - 1);
          for (int j = 0; j < k; j++)
            push_byte(8'($urandom_range(8'h80, 8'hBF)), PRD, '0);
          case ($urandom_range(0, 2))
            0: push_byte(8'($urandom_range(8'hC0, 8'hFF)), PRD, '0);
            1: push_byte(8'h00, PRD, '0);
            default: push_byte(8'($urandom_range(1, 8'h7F)), PRD, '0);
          endcase
          ph_bytes += k + 2;
        end else begin
          // noise over the full byte range
          push_byte(8'($urandom_range(0, 255)), PRD, '0);
          ph_bytes++;
        end
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (cp_pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run covered %0d byte requests (%0d in remap mode), %0d code points checked",
             bytes_sent, remap_bytes, cp_seen);
    $display("%0d code points were nonzero, %0d mismatches", cp_nonzero, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
